@@ hw/rtl/vfp_pkg.sv @@
// Shared types and constants of the voice fade and playback controller.
// Used by vfp_divider and voice_fade_playback_controller_top; no dependencies.

package vfp_pkg;

  localparam int unsigned VolW   = 16;
  localparam int unsigned PosW   = 32;
  localparam int unsigned ElapW  = 17;
  localparam int unsigned AmtW   = 16;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned CfgIdxW = 2;

  // Shared divider: 33-bit dividend, 32-bit divisor.
  localparam int unsigned DivNumW = 33;
  localparam int unsigned DivDenW = 32;
  localparam int unsigned DivCntW = $clog2(DivNumW + 1);

  localparam logic [VolW-1:0] VolFull = {VolW{1'b1}};

  typedef enum logic [2:0] {
    ST_STOPPED  = 3'd0,
    ST_PLAYING  = 3'd1,
    ST_PAUSED   = 3'd2,
    ST_FADE_IN  = 3'd3,
    ST_FADE_OUT = 3'd4
  } vfp_play_e;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_PLAY     = 3'd1,
    OP_PAUSE    = 3'd2,
    OP_STOP     = 3'd3,
    OP_FADE_IN  = 3'd4,
    OP_FADE_OUT = 3'd5
  } vfp_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TRACK_LEN = 2'd0,
    CFG_LOOP_EN   = 2'd1,
    CFG_BASE_VOL  = 2'd2
  } vfp_cfg_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_FADE_MUL,
    SEQ_FADE_DIV,
    SEQ_FADE_WAIT,
    SEQ_POS,
    SEQ_POS_WAIT,
    SEQ_DONE
  } vfp_seq_e;

  typedef struct packed {
    logic busy;
    logic done;
  } vfp_div_status_t;

endpackage

@@ hw/rtl/vfp_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle, shared by the
// fade ratio and the position wrap. Depends on vfp_pkg.

module vfp_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [vfp_pkg::DivNumW-1:0]  dividend_i,
  input  logic [vfp_pkg::DivDenW-1:0]  divisor_i,
  output vfp_pkg::vfp_div_status_t     status_o,
  output logic [vfp_pkg::DivNumW-1:0]  quotient_o,
  output logic [vfp_pkg::DivDenW-1:0]  remainder_o
);
  import vfp_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivDenW-1:0] rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] dvs_q, dvs_d;

  logic [DivDenW:0]   shifted;
  logic [DivDenW+1:0] trial;
  logic               fits;

  assign shifted = {rem_q, quo_q[DivNumW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_q};
  assign fits    = ~trial[DivDenW+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNumW);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so its low bits suffice.
      rem_d = fits ? trial[DivDenW-1:0] : shifted[DivDenW-1:0];
      quo_d = {quo_q[DivNumW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

`ifndef SYNTH
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider reports done while still busy");
  a_busy_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with an exhausted bit count");
  a_start_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_q) |=> (busy_q && cnt_q == DivCntW'(DivNumW)))
    else $error("divider did not begin a full run after start");
`endif

endmodule

@@ hw/rtl/voice_fade_playback_controller_top.sv @@
// Top level of the voice fade and playback controller: command sequencer,
// voice state, configuration registers and result register.
// Depends on vfp_pkg and vfp_divider.

// Usage. Commands arrive as beats on the slave stream: tuser carries the
// opcode (tick, play, pause, stop, fade in, fade out) and tdata carries the
// amount and the stop-when-done flag. Every accepted beat yields exactly one
// result beat on the master stream with the play state, volume, position and
// an ended flag, in command order.
// Sequencing. A command other than a tick goes from acceptance to the done
// state, where it is loaded into the result register, and the sequencer then
// returns to idle for the next beat; a tick that moves the position without a
// division passes through the position state first. A tick that wraps the
// position, or one that advances a fade still in progress, runs the shared divider,
// which resolves one quotient bit per cycle; a fade step first runs the multiply,
// divide and wait states, and a wrap waits in the position wait state. One command is in flight at a time.
// Reset. rst_ni is asynchronous and active low; it stops the voice, sets the
// volume and base volume to full scale, clears track length and looping, and
// empties the result register.
// Stalls. The result register holds a finished beat while the receiver is not
// ready; a new command may already be accepted, and its result waits in the
// sequencer until the register is free.
// Configuration writes on cfg_we_i take effect at once and are meant to be
// issued while no command is in flight.

module voice_fade_playback_controller_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Command stream.
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [23:0]                  s_axis_tdata,  // [15:0] amount, [16] stop_when_done
  input  logic [2:0]                   s_axis_tuser,  // [2:0] opcode
  // Result stream.
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [55:0]                  m_axis_tdata,  // [2:0] play_state_out,
                                                      // [18:3] volume_out,
                                                      // [50:19] position_out,
                                                      // [51] ended
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [vfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vfp_pkg::CfgW-1:0]     cfg_data_i
);
  import vfp_pkg::*;

  // Configuration registers.
  logic [PosW-1:0] track_len_q;
  logic            loop_en_q;
  logic [VolW-1:0] base_vol_q;

  // Voice state.
  vfp_play_e        play_q, play_d;
  logic [VolW-1:0]  vol_q, vol_d;
  logic [VolW-1:0]  fstart_q, fstart_d;
  logic [VolW-1:0]  ftarget_q, ftarget_d;
  logic [VolW-1:0]  flen_q, flen_d;
  logic [ElapW-1:0] felap_q, felap_d;
  logic             saf_q, saf_d;
  logic [PosW-1:0]  pos_q, pos_d;

  // Sequencer and working registers.
  vfp_seq_e         seq_q, seq_d;
  logic             was_stopped_q, was_stopped_d;
  logic [AmtW-1:0]  amt_q, amt_d;
  logic [2*VolW-1:0] prod_q, prod_d;
  logic             up_q, up_d;

  // Result register.
  logic             out_valid_q, out_valid_d;
  logic [55:0]      out_data_q, out_data_d;

  // Divider connection.
  logic               div_start;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  vfp_div_status_t    div_st;
  logic [DivNumW-1:0] div_quo;
  logic [DivDenW-1:0] div_rem;

  // Command fields and shared combinational terms.
  logic [2:0]       in_op;
  logic [AmtW-1:0]  in_amt;
  logic             in_swd;
  logic             accept;
  logic [ElapW-1:0] elap_sum;
  logic [PosW:0]    pos_sum;
  logic             pos_over;
  logic [VolW-1:0]  span;
  logic             out_free;
  logic             ended;

  assign in_op    = s_axis_tuser;
  assign in_amt   = s_axis_tdata[AmtW-1:0];
  assign in_swd   = s_axis_tdata[AmtW];
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign elap_sum = felap_q + {1'b0, in_amt};
  assign pos_sum  = {1'b0, pos_q} + {{(PosW+1-AmtW){1'b0}}, amt_q};
  assign pos_over = (track_len_q != '0) && (pos_sum >= {1'b0, track_len_q});
  assign span     = (ftarget_q >= fstart_q) ? (ftarget_q - fstart_q)
                                            : (fstart_q - ftarget_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign ended    = was_stopped_q == 1'b0 && play_q == ST_STOPPED;

  vfp_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_num),
    .divisor_i   (div_den),
    .status_o    (div_st),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Next state of the sequencer.
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          seq_d = SEQ_DONE;
          if (in_op == OP_TICK) begin
            if (play_q == ST_PLAYING) begin
              seq_d = SEQ_POS;
            end else if (play_q == ST_FADE_IN || play_q == ST_FADE_OUT) begin
              if (elap_sum < {1'b0, flen_q}) begin
                seq_d = SEQ_FADE_MUL;
              end else if (!(play_q == ST_FADE_OUT && saf_q)) begin
                seq_d = SEQ_POS;
              end
            end
          end
        end
      end
      SEQ_FADE_MUL:  seq_d = SEQ_FADE_DIV;
      SEQ_FADE_DIV:  seq_d = SEQ_FADE_WAIT;
      SEQ_FADE_WAIT: if (div_st.done) seq_d = SEQ_POS;
      SEQ_POS: begin
        seq_d = (pos_over && loop_en_q) ? SEQ_POS_WAIT : SEQ_DONE;
      end
      SEQ_POS_WAIT:  if (div_st.done) seq_d = SEQ_DONE;
      SEQ_DONE:      if (out_free) seq_d = SEQ_IDLE;
      default:       seq_d = SEQ_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider requests.
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    div_num       = {1'b0, prod_q};
    div_den       = {{(DivDenW-VolW){1'b0}}, flen_q};
    unique case (seq_q)
      SEQ_IDLE:     s_axis_tready = 1'b1;
      SEQ_FADE_DIV: div_start = 1'b1;
      SEQ_POS: begin
        div_start = pos_over && loop_en_q;
        div_num   = pos_sum;
        div_den   = track_len_q;
      end
      default: ;
    endcase
  end

  // Voice state and result register updates.
  always_comb begin
    play_d        = play_q;
    vol_d         = vol_q;
    fstart_d      = fstart_q;
    ftarget_d     = ftarget_q;
    flen_d        = flen_q;
    felap_d       = felap_q;
    saf_d         = saf_q;
    pos_d         = pos_q;
    was_stopped_d = was_stopped_q;
    amt_d         = amt_q;
    prod_d        = prod_q;
    up_d          = up_q;
    out_valid_d   = out_valid_q;
    out_data_d    = out_data_q;

    if (m_axis_tready) out_valid_d = 1'b0;

    if (cfg_we_i && cfg_idx_i == CFG_BASE_VOL) vol_d = cfg_data_i[VolW-1:0];

    unique case (seq_q)
      SEQ_IDLE: begin
        if (accept) begin
          was_stopped_d = (play_q == ST_STOPPED);
          amt_d         = in_amt;
          unique case (in_op)
            OP_TICK: begin
              if (play_q == ST_FADE_IN || play_q == ST_FADE_OUT) begin
                felap_d = elap_sum;
                if (elap_sum >= {1'b0, flen_q}) begin
                  vol_d = ftarget_q;
                  if (play_q == ST_FADE_OUT && saf_q) begin
                    play_d  = ST_STOPPED;
                    pos_d   = '0;
                    felap_d = '0;
                  end else begin
                    play_d = ST_PLAYING;
                  end
                end
              end
            end
            OP_PLAY: begin
              if (play_q == ST_PAUSED) begin
                play_d = ST_PLAYING;
              end else if (play_q == ST_STOPPED) begin
                play_d = ST_PLAYING;
                pos_d  = '0;
              end
            end
            OP_PAUSE: begin
              if (play_q == ST_PLAYING || play_q == ST_FADE_IN ||
                  play_q == ST_FADE_OUT) begin
                play_d = ST_PAUSED;
              end
            end
            OP_STOP: begin
              play_d  = ST_STOPPED;
              pos_d   = '0;
              felap_d = '0;
            end
            OP_FADE_IN: begin
              if (in_amt == '0) begin
                vol_d  = base_vol_q;
                play_d = ST_PLAYING;
              end else begin
                fstart_d  = '0;
                ftarget_d = base_vol_q;
                flen_d    = in_amt;
                felap_d   = '0;
                saf_d     = 1'b0;
                vol_d     = '0;
                play_d    = ST_FADE_IN;
              end
            end
            OP_FADE_OUT: begin
              if (in_amt == '0) begin
                if (in_swd) begin
                  play_d  = ST_STOPPED;
                  pos_d   = '0;
                  felap_d = '0;
                end else begin
                  vol_d = '0;
                end
              end else begin
                fstart_d  = vol_q;
                ftarget_d = '0;
                flen_d    = in_amt;
                felap_d   = '0;
                saf_d     = in_swd;
                play_d    = ST_FADE_OUT;
              end
            end
            default: ;
          endcase
        end
      end
      SEQ_FADE_MUL: begin
        // The elapsed time is below the fade length here, so 16 bits hold it.
        prod_d = span * felap_q[VolW-1:0];
        up_d   = (ftarget_q >= fstart_q);
      end
      SEQ_FADE_WAIT: begin
        if (div_st.done) begin
          vol_d = up_q ? (fstart_q + div_quo[VolW-1:0])
                       : (fstart_q - div_quo[VolW-1:0]);
        end
      end
      SEQ_POS: begin
        if (!pos_over) begin
          pos_d = pos_sum[PosW-1:0];
        end else if (!loop_en_q) begin
          play_d  = ST_STOPPED;
          pos_d   = '0;
          felap_d = '0;
        end
      end
      SEQ_POS_WAIT: begin
        if (div_st.done) pos_d = div_rem;
      end
      SEQ_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {4'b0000, ended, pos_q, vol_q, play_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= SEQ_IDLE;
      out_valid_q   <= 1'b0;
      track_len_q   <= '0;
      loop_en_q     <= 1'b0;
      base_vol_q    <= VolFull;
      play_q        <= ST_STOPPED;
      vol_q         <= VolFull;
      fstart_q      <= '0;
      ftarget_q     <= '0;
      flen_q        <= '0;
      felap_q       <= '0;
      saf_q         <= 1'b0;
      pos_q         <= '0;
      was_stopped_q <= 1'b1;
    end else begin
      seq_q         <= seq_d;
      out_valid_q   <= out_valid_d;
      play_q        <= play_d;
      vol_q         <= vol_d;
      fstart_q      <= fstart_d;
      ftarget_q     <= ftarget_d;
      flen_q        <= flen_d;
      felap_q       <= felap_d;
      saf_q         <= saf_d;
      pos_q         <= pos_d;
      was_stopped_q <= was_stopped_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TRACK_LEN: track_len_q <= cfg_data_i;
          CFG_LOOP_EN:   loop_en_q   <= cfg_data_i[0];
          CFG_BASE_VOL:  base_vol_q  <= cfg_data_i[VolW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    amt_q      <= amt_d;
    prod_q     <= prod_d;
    up_q       <= up_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
  a_div_done_waited : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (seq_q == SEQ_FADE_WAIT || seq_q == SEQ_POS_WAIT))
    else $error("division finished while the sequencer was not waiting for it");
  a_ended_stopped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[51]) |-> out_data_q[2:0] == ST_STOPPED)
    else $error("result flags ended without a stopped voice");
  a_no_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("division requested while the divider is busy");
  a_out_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled result beat changed");
`endif

endmodule
